@@ rtl/lzhw_pkg.sv @@
// Shared types and constants for the LZ history window block.
`timescale 1ns / 1ps
`default_nettype none

package lzhw_pkg;

   // Operation codes carried in a request
   localparam logic [1:0] OP_LITERAL = 2'd0;
   localparam logic [1:0] OP_COPY    = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // Fixed field widths
   localparam int BYTE_W    = 8;
   localparam int OFFSET_W  = 12;
   localparam int POS_OUT_W = 12;
   localparam int CFG_W     = 4;

   // Window size register value after reset
   localparam logic [CFG_W-1:0] WINDOW_LOG2_RESET = 4'd12;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [BYTE_W-1:0]   literal_byte;
      logic [OFFSET_W-1:0] copy_offset;
      logic                run_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 window_filled;
      logic [POS_OUT_W-1:0] next_write_position;
      logic                 run_last;
   } rsp_payload_type;

   // Per-request control flags handed from address generation to the datapath
   typedef struct packed {
      logic emit;     // request produces a response
      logic write;    // literal or copy: stores a byte
      logic copy;     // byte comes from the history
      logic read_ok;  // source entry written since last clear
   } issue_type;

endpackage

`default_nettype wire

@@ rtl/lzhw_req_if.sv @@
// Request channel interface: valid/ready handshake with request payload.
`timescale 1ns / 1ps
`default_nettype none

interface lzhw_req_if import lzhw_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lzhw_rsp_if.sv @@
// Response channel interface: valid/ready handshake with response payload.
`timescale 1ns / 1ps
`default_nettype none

interface lzhw_rsp_if import lzhw_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lzhw_hist_ram.sv @@
// History byte memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lzhw_hist_ram import lzhw_pkg::*; #(
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0]    wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [BYTE_W-1:0]    rd_data_ff
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [BYTE_W-1:0] store_mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/lzhw_addr_gen.sv @@
// Window size register, write position, fill mark and address generation.
`timescale 1ns / 1ps
`default_nettype none

module lzhw_addr_gen import lzhw_pkg::*; #(
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CFG_W-1:0]     csr_wr_data,
   input  wire logic                 accept,
   input  wire logic [1:0]           opcode,
   input  wire logic [OFFSET_W-1:0]  copy_offset,
   output logic      [ADDR_BITS-1:0] wr_addr,
   output logic      [ADDR_BITS-1:0] rd_addr,
   output logic      [ADDR_BITS-1:0] next_pos,
   output logic                      next_filled,
   output issue_type                 issue
);

   logic [CFG_W-1:0]     window_log2_ff;
   logic [ADDR_BITS-1:0] pos_ff, pos_in;
   logic                 filled_ff, filled_in;
   // count of entries written since clear; written entries form [0, hwm)
   logic [ADDR_BITS:0]   hwm_ff, hwm_in;

   logic [4:0]           wl_ext;
   logic [4:0]           lg;
   logic [ADDR_BITS-1:0] mask;
   logic [ADDR_BITS-1:0] cur_pos;
   logic [ADDR_BITS-1:0] step_pos;
   logic [ADDR_BITS:0]   hwm_step;

   // clamp window size to [1, ADDR_BITS] and build the mask
   always_comb begin
      wl_ext = {1'b0, window_log2_ff};
      if (wl_ext > 5'(ADDR_BITS)) begin
         lg = 5'(ADDR_BITS);
      end else if (wl_ext == 5'd0) begin
         lg = 5'd1;
      end else begin
         lg = wl_ext;
      end
      mask = ~({ADDR_BITS{1'b1}} << lg);
   end

   // addresses for this request
   always_comb begin
      cur_pos  = pos_ff & mask;
      rd_addr  = (cur_pos + ADDR_BITS'(copy_offset)) & mask;
      step_pos = (cur_pos + ADDR_BITS'(1)) & mask;
      hwm_step = ({1'b0, cur_pos} == hwm_ff) ? hwm_ff + (ADDR_BITS+1)'(1) : hwm_ff;
      wr_addr  = cur_pos;
   end

   // next state per operation
   always_comb begin
      pos_in    = pos_ff;
      filled_in = filled_ff;
      hwm_in    = hwm_ff;
      case (opcode) inside
         OP_LITERAL, OP_COPY: begin
            pos_in    = step_pos;
            filled_in = filled_ff | (step_pos == '0);
            hwm_in    = hwm_step;
         end
         OP_CLEAR: begin
            pos_in    = '0;
            filled_in = 1'b0;
            hwm_in    = '0;
         end
         default: begin
         end
      endcase
   end

   assign next_pos      = pos_in;
   assign next_filled   = filled_in;
   assign issue.emit    = (opcode != OP_NONE);
   assign issue.write   = (opcode == OP_LITERAL) || (opcode == OP_COPY);
   assign issue.copy    = (opcode == OP_COPY);
   assign issue.read_ok = ({1'b0, rd_addr} < hwm_ff);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_log2_ff <= WINDOW_LOG2_RESET;
         pos_ff         <= '0;
         filled_ff      <= 1'b0;
         hwm_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            window_log2_ff <= csr_wr_data;
         end
         if (accept) begin
            pos_ff    <= pos_in;
            filled_ff <= filled_in;
            hwm_ff    <= hwm_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/lz_history_window_copy_top.sv @@
// Top level of the LZ history window: channels, byte datapath and response register.
//
// Usage:
//   req_ch carries one operation per request: literal write, copy from offset,
//   or clear. rsp_ch returns one response per literal, copy or clear with the
//   stored byte, the filled flag, the next write position and the run mark.
//   Opcode 3 is accepted and produces no response.
//   csr_wr_en/csr_wr_data write window_log2; write it only while the block is idle.
// Pipeline and throughput:
//   A request is accepted into the byte stage as its history read completes,
//   and its response is registered once the response register is free or taken.
//   One request per cycle is sustained while rsp_ch.ready is high; a copy that
//   reads the byte the request just ahead writes is served by a forwarding register.
// Reset:
//   Position, filled flag and fill mark clear on reset; history entries not
//   written since the last clear read as zero, so no memory sweep is needed.
//   A clear request resets them the same way. window_log2 resets to 12.
// Stall:
//   When rsp_ch.ready is low with a response waiting, that register and the byte
//   stage hold, and req_ch.ready drops once both are occupied; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module lz_history_window_copy_top import lzhw_pkg::*; #(
   parameter int ADDR_BITS = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   lzhw_req_if.sink              req_ch,
   lzhw_rsp_if.source            rsp_ch
);

   logic                 accept;
   logic                 adv;
   logic                 b_go;
   logic                 wr_en;

   logic [ADDR_BITS-1:0] ag_wr_addr;
   logic [ADDR_BITS-1:0] ag_rd_addr;
   logic [ADDR_BITS-1:0] ag_next_pos;
   logic                 ag_next_filled;
   issue_type            ag_issue;

   // byte stage registers
   logic                 b_vld_ff, b_vld_in;
   issue_type            b_issue_ff;
   logic [ADDR_BITS-1:0] b_wr_addr_ff;
   logic [ADDR_BITS-1:0] b_next_pos_ff;
   logic                 b_filled_ff;
   logic [BYTE_W-1:0]    b_literal_ff;
   logic                 b_run_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [BYTE_W-1:0]    fwd_byte_ff;
   logic [BYTE_W-1:0]    mem_rd_data;
   logic [BYTE_W-1:0]    b_byte;

   // response register
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_payload_type      rsp_data_ff;

   // handshake
   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign b_go         = b_vld_ff && adv;
   assign req_ch.ready = !b_vld_ff || adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_en        = b_go && b_issue_ff.write;

   lzhw_addr_gen #(.ADDR_BITS(ADDR_BITS)) u_addr_gen (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .opcode      (req_ch.data.opcode),
      .copy_offset (req_ch.data.copy_offset),
      .wr_addr     (ag_wr_addr),
      .rd_addr     (ag_rd_addr),
      .next_pos    (ag_next_pos),
      .next_filled (ag_next_filled),
      .issue       (ag_issue)
   );

   lzhw_hist_ram #(.ADDR_BITS(ADDR_BITS)) u_hist_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (b_wr_addr_ff),
      .wr_data    (b_byte),
      .rd_en      (accept),
      .rd_addr    (ag_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // byte select: unwritten entries read as zero, forward the write just ahead
   always_comb begin
      if (!b_issue_ff.write) begin
         b_byte = '0;
      end else if (!b_issue_ff.copy) begin
         b_byte = b_literal_ff;
      end else if (!b_issue_ff.read_ok) begin
         b_byte = '0;
      end else if (fwd_hit_ff) begin
         b_byte = fwd_byte_ff;
      end else begin
         b_byte = mem_rd_data;
      end
   end

   // byte stage next state
   always_comb begin
      fwd_hit_in = wr_en && (b_wr_addr_ff == ag_rd_addr);
      if (accept) begin
         b_vld_in = ag_issue.emit;
      end else if (b_go) begin
         b_vld_in = 1'b0;
      end else begin
         b_vld_in = b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_issue_ff    <= ag_issue;
         b_wr_addr_ff  <= ag_wr_addr;
         b_next_pos_ff <= ag_next_pos;
         b_filled_ff   <= ag_next_filled;
         b_literal_ff  <= req_ch.data.literal_byte;
         b_run_ff      <= req_ch.data.run_end;
         fwd_hit_ff    <= fwd_hit_in;
         fwd_byte_ff   <= b_byte;
      end
   end

   // response register
   always_comb begin
      if (b_go) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         rsp_data_ff.out_byte            <= b_byte;
         rsp_data_ff.window_filled       <= b_filled_ff;
         rsp_data_ff.next_write_position <= POS_OUT_W'(b_next_pos_ff);
         rsp_data_ff.run_last            <= b_run_ff;
      end
   end

   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the LZ history window: a directed table, then random runs checked by a predictor.
`timescale 1ns / 1ps

module testbench;
   import lzhw_pkg::*;

   localparam int ADDR_BITS   = 12;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int SETTLE_WAIT = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 60;
   localparam int LONG_HOLD   = 150;
   localparam int NUM_PHASES  = 12;

   // One row of the directed table: a window write or a request
   typedef struct packed {
      logic             is_cfg;
      logic [CFG_W-1:0] cfg_val;
      req_payload_type  req;
      logic             typed;
      rsp_payload_type  want;
   } dir_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   lzhw_req_if req_ch ();
   lzhw_rsp_if rsp_ch ();

   lz_history_window_copy_top #(
      .ADDR_BITS(ADDR_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Predicted window state
   logic [BYTE_W-1:0]    hist_mem [STORE_DEPTH];
   logic [ADDR_BITS-1:0] hist_pos;
   logic                 hist_filled;
   logic [CFG_W-1:0]     hist_log2;

   rsp_payload_type pending_rsp [$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   bit              hold_off_req   = 1'b0;

   always #6 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Effective window mask: log2 clamped to 1..ADDR_BITS
   function automatic logic [ADDR_BITS-1:0] window_mask();
      int lg;
      lg = hist_log2;
      if (lg > ADDR_BITS) lg = ADDR_BITS;
      if (lg < 1) lg = 1;
      return ADDR_BITS'((1 << lg) - 1);
   endfunction

   // Apply one request to the predicted window and form its response
   task automatic advance_history(input req_payload_type r, output bit emits,
                                  output rsp_payload_type r_out);
      logic [ADDR_BITS-1:0] msk;
      logic [ADDR_BITS-1:0] p;
      logic [BYTE_W-1:0]    b;
      msk   = window_mask();
      p     = hist_pos & msk;
      b     = '0;
      emits = (r.opcode != OP_NONE);
      r_out = '0;
      if (r.opcode == OP_CLEAR) begin
         for (int i = 0; i < STORE_DEPTH; i++) hist_mem[i] = '0;
         hist_pos    = '0;
         hist_filled = 1'b0;
      end else if (r.opcode != OP_NONE) begin
         if (r.opcode == OP_COPY)
            b = hist_mem[(p + ADDR_BITS'(r.copy_offset)) & msk];
         else
            b = r.literal_byte;
         hist_mem[p] = b;
         p = (p + 1'b1) & msk;
         if (p == '0) hist_filled = 1'b1;
         hist_pos = p;
      end
      if (emits) begin
         r_out.out_byte            = b;
         r_out.window_filled       = hist_filled;
         r_out.next_write_position = POS_OUT_W'(hist_pos);
         r_out.run_last            = r.run_end;
      end
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                  cycle_count, what, got, want);
   endtask

   // Table row builders
   function automatic dir_row_type op_row(logic [1:0] op, logic [BYTE_W-1:0] lit,
                                          logic [OFFSET_W-1:0] off, logic run);
      dir_row_type t;
      t = '0;
      t.req.opcode       = op;
      t.req.literal_byte = lit;
      t.req.copy_offset  = off;
      t.req.run_end      = run;
      return t;
   endfunction

   function automatic dir_row_type known_row(logic [1:0] op, logic [BYTE_W-1:0] lit,
                                             logic [OFFSET_W-1:0] off, logic run,
                                             logic [BYTE_W-1:0] b, logic f,
                                             logic [POS_OUT_W-1:0] p);
      dir_row_type t;
      t = op_row(op, lit, off, run);
      t.typed                    = 1'b1;
      t.want.out_byte            = b;
      t.want.window_filled       = f;
      t.want.next_write_position = p;
      t.want.run_last            = run;
      return t;
   endfunction

   function automatic dir_row_type cfg_row(logic [CFG_W-1:0] v);
      dir_row_type t;
      t = '0;
      t.is_cfg  = 1'b1;
      t.cfg_val = v;
      return t;
   endfunction

   // Offer one request, wait for accept, then log its expected response
   task automatic offer_request(input req_payload_type r, input bit burst,
                                input bit typed, input rsp_payload_type typed_rsp);
      int gap;
      int pick;
      bit emits;
      rsp_payload_type predicted;
      pick = $urandom_range(0, 99);
      if (burst || pick < 60)
         gap = 0;
      else if (pick < 90)
         gap = $urandom_range(1, 3);
      else if (pick < 97)
         gap = $urandom_range(4, 10);
      else
         gap = $urandom_range(15, 40);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      advance_history(r, emits, predicted);
      if (emits) pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Window size change, only with the block drained
   task automatic write_window(input logic [CFG_W-1:0] v);
      wait_idle();
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hist_log2 = v;
   endtask

   // One random burst: mostly well-formed literal or copy runs, some noise and clears
   task automatic offer_random_run(input bit burst, inout int counted);
      req_payload_type r;
      int pick;
      int len;
      int back_dist;
      int msk;
      bit is_copy;
      bit broken;
      logic [OFFSET_W-1:0] off;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r = req_payload_type'($urandom);
         offer_request(r, burst, 1'b0, '0);
         if (r.opcode != OP_NONE) counted++;
      end else if (pick < 12) begin
         r = req_payload_type'($urandom);
         r.opcode = OP_CLEAR;
         offer_request(r, burst, 1'b0, '0);
         counted++;
      end else begin
         len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         is_copy   = ($urandom_range(0, 99) < 55);
         broken    = ($urandom_range(0, 9) == 0);
         msk       = int'(window_mask());
         back_dist = $urandom_range(1, msk + 1);
         // back distance inside the window, random bits above it
         off       = OFFSET_W'(($urandom & ~msk) | ((msk + 1 - back_dist) & msk));
         for (int i = 0; i < len; i++) begin
            r              = req_payload_type'($urandom);
            r.opcode       = is_copy ? OP_COPY : OP_LITERAL;
            if (is_copy) r.copy_offset = off;
            r.run_end      = (i == len - 1) && !broken;
            offer_request(r, burst, 1'b0, '0);
            counted++;
         end
      end
   endtask

   // Response side: scoreboard check and ready pattern
   initial begin : rsp_side
      int low_left;
      int idle_pct;
      bit hold_done;
      rsp_payload_type want;
      low_left  = 0;
      idle_pct  = 0;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
               flag_mismatch("response with none pending", 1, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_ch.data.out_byte !== want.out_byte)
                  flag_mismatch("out_byte", int'(rsp_ch.data.out_byte),
                                int'(want.out_byte));
               if (rsp_ch.data.window_filled !== want.window_filled)
                  flag_mismatch("window_filled", int'(rsp_ch.data.window_filled),
                                int'(want.window_filled));
               if (rsp_ch.data.next_write_position !== want.next_write_position)
                  flag_mismatch("next_write_position",
                                int'(rsp_ch.data.next_write_position),
                                int'(want.next_write_position));
               if (rsp_ch.data.run_last !== want.run_last)
                  flag_mismatch("run_last", int'(rsp_ch.data.run_last),
                                int'(want.run_last));
            end
         end
         // stall density changes now and then, zero included
         if (cycle_count % 128 == 0) begin
            case ($urandom_range(0, 3))
               0: idle_pct = 0;
               1: idle_pct = 10;
               2: idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            low_left  = LONG_HOLD;
         end
         if (low_left > 0) begin
            low_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            low_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Request side: reset, directed table, random phases, drain
   initial begin : req_side
      dir_row_type      rows [$];
      logic [CFG_W-1:0] phase_log2 [NUM_PHASES];
      int               counted;
      int               phase_count;
      bit               burst;
      bit               hold_sent;
      bit               paused;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      for (int i = 0; i < STORE_DEPTH; i++) hist_mem[i] = '0;
      hist_pos    = '0;
      hist_filled = 1'b0;
      hist_log2   = WINDOW_LOG2_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Full window after reset: unwritten reads, byte extremes, offset extremes
      rows.push_back(known_row(OP_COPY, 8'h00, 12'h000, 1'b0, 8'h00, 1'b0, 12'd1));
      rows.push_back(known_row(OP_LITERAL, 8'hFF, 12'hFFF, 1'b1, 8'hFF, 1'b0, 12'd2));
      rows.push_back(known_row(OP_LITERAL, 8'h00, 12'h000, 1'b0, 8'h00, 1'b0, 12'd3));
      rows.push_back(op_row(OP_COPY, 8'hFF, 12'hFFE, 1'b0));
      rows.push_back(op_row(OP_NONE, 8'h55, 12'hFFF, 1'b1));
      rows.push_back(op_row(OP_COPY, 8'h00, 12'hFFF, 1'b0));
      rows.push_back(known_row(OP_CLEAR, 8'hFF, 12'hFFF, 1'b1, 8'h00, 1'b0, 12'd0));
      rows.push_back(known_row(OP_COPY, 8'h00, 12'hFFF, 1'b0, 8'h00, 1'b0, 12'd1));
      // log2 of zero acts as one: wrap sets filled, zero offset reads in place
      rows.push_back(cfg_row(4'd0));
      rows.push_back(op_row(OP_LITERAL, 8'h3C, 12'h000, 1'b0));
      rows.push_back(op_row(OP_COPY, 8'h00, 12'h001, 1'b0));
      rows.push_back(op_row(OP_COPY, 8'h00, 12'h000, 1'b1));
      // log2 above the built depth acts as the full depth
      rows.push_back(cfg_row(4'd15));
      rows.push_back(op_row(OP_LITERAL, 8'h81, 12'h5A5, 1'b0));
      rows.push_back(op_row(OP_COPY, 8'h00, 12'hFFF, 1'b0));
      // shrink mid-stream: position masked on next use
      rows.push_back(cfg_row(4'd1));
      rows.push_back(op_row(OP_LITERAL, 8'h7E, 12'h000, 1'b1));
      rows.push_back(op_row(OP_COPY, 8'h00, 12'hFFF, 1'b0));
      rows.push_back(known_row(OP_CLEAR, 8'h00, 12'h000, 1'b0, 8'h00, 1'b0, 12'd0));

      foreach (rows[i]) begin
         if (rows[i].is_cfg)
            write_window(rows[i].cfg_val);
         else
            offer_request(rows[i].req, 1'b0, rows[i].typed, rows[i].want);
      end

      // Random phases over a spread of window sizes
      phase_log2 = '{4'd3, 4'd1, 4'd12, 4'd2, 4'd14, 4'd4, 4'd0, 4'd6, 4'd13, 4'd2, 4'd9, 4'd5};
      counted   = 0;
      hold_sent = 1'b0;
      paused    = 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_window(phase_log2[ph]);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            offer_random_run(burst, phase_count);
            if (!hold_sent && counted + phase_count >= 150) begin
               // receiver holds off while requests keep coming
               hold_sent = 1'b1;
               hold_off_req <= 1'b1;
            end
            if (!paused && counted + phase_count >= 450) begin
               paused = 1'b1;
               wait_idle();
            end
         end
         counted += phase_count;
      end

      wait_idle();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lzhw_pkg.sv
rtl/lzhw_req_if.sv
rtl/lzhw_rsp_if.sv
rtl/lzhw_hist_ram.sv
rtl/lzhw_addr_gen.sv
rtl/lz_history_window_copy_top.sv
verif/testbench.sv
